>>> src/owtr_pkg.sv
// Shared types and constants for the single-wire temperature reader.
// No dependencies; owtr_cfg, owtr_seq and the core module import this package.
`timescale 1ns / 1ps

package owtr_pkg;

    // Field and state widths
    localparam int unsigned PhaseW   = 5;
    localparam int unsigned ElapsedW = 20;
    localparam int unsigned BitIdxW  = 3;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned TempW    = 16;
    localparam int unsigned ErrW     = 2;
    localparam int unsigned ShortW   = 10;
    localparam int unsigned CfgDataW = 20;
    localparam int unsigned CfgIdxW  = 2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_RESET_LOW    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PRES_TIMEOUT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_REL_TIMEOUT  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_POLL_WAIT    = 2'd3;

    // Configuration reset values
    localparam logic [ShortW-1:0]   RESET_LOW_DEF    = 10'd480;
    localparam logic [ShortW-1:0]   PRES_TIMEOUT_DEF = 10'd100;
    localparam logic [ShortW-1:0]   REL_TIMEOUT_DEF  = 10'd300;
    localparam logic [CfgDataW-1:0] POLL_WAIT_DEF    = 20'd50000;

    // Error codes
    localparam logic [ErrW-1:0] ERR_NONE        = 2'd0;
    localparam logic [ErrW-1:0] ERR_NO_PRESENCE = 2'd1;
    localparam logic [ErrW-1:0] ERR_NO_RELEASE  = 2'd2;

    // Bus commands
    localparam logic [ByteW-1:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [ByteW-1:0] CMD_CONVERT  = 8'h44;
    localparam logic [ByteW-1:0] CMD_READ_PAD = 8'hBE;
    localparam logic [ByteW-1:0] CONV_DONE    = 8'hFF;

    // Slot timing in microsecond ticks; each line change costs two ticks
    localparam logic [ElapsedW-1:0] EDGE_US        = 20'd2;
    localparam logic [ElapsedW-1:0] BIT1_LOW_US    = 20'd17;
    localparam logic [ElapsedW-1:0] BIT1_SLOT_US   = 20'd64;
    localparam logic [ElapsedW-1:0] BIT0_LOW_US    = 20'd57;
    localparam logic [ElapsedW-1:0] BIT0_SLOT_US   = 20'd59;
    localparam logic [ElapsedW-1:0] RD_LOW_US      = 20'd7;
    localparam logic [ElapsedW-1:0] RD_SAMPLE_US   = 20'd14;
    localparam logic [ElapsedW-1:0] RD_SLOT_US     = 20'd64;
    localparam logic [ElapsedW-1:0] AFTER_RESET_US = 20'd10000;
    localparam logic [ElapsedW-1:0] AFTER_CMD_US   = 20'd1000;

    // Sequencer phases
    localparam logic [PhaseW-1:0] PH_IDLE     = 5'd0;
    localparam logic [PhaseW-1:0] PH_R1_LOW   = 5'd1;
    localparam logic [PhaseW-1:0] PH_R1_REL   = 5'd2;
    localparam logic [PhaseW-1:0] PH_R1_PRES  = 5'd3;
    localparam logic [PhaseW-1:0] PH_R1_FREE  = 5'd4;
    localparam logic [PhaseW-1:0] PH_WAIT10   = 5'd5;
    localparam logic [PhaseW-1:0] PH_W_CC1    = 5'd6;
    localparam logic [PhaseW-1:0] PH_W_44     = 5'd7;
    localparam logic [PhaseW-1:0] PH_WAIT1A   = 5'd8;
    localparam logic [PhaseW-1:0] PH_POLL     = 5'd9;
    localparam logic [PhaseW-1:0] PH_POLLWAIT = 5'd10;
    localparam logic [PhaseW-1:0] PH_R2_LOW   = 5'd11;
    localparam logic [PhaseW-1:0] PH_R2_REL   = 5'd12;
    localparam logic [PhaseW-1:0] PH_R2_PRES  = 5'd13;
    localparam logic [PhaseW-1:0] PH_R2_FREE  = 5'd14;
    localparam logic [PhaseW-1:0] PH_W_CC2    = 5'd15;
    localparam logic [PhaseW-1:0] PH_W_BE     = 5'd16;
    localparam logic [PhaseW-1:0] PH_WAIT1B   = 5'd17;
    localparam logic [PhaseW-1:0] PH_READ_L   = 5'd18;
    localparam logic [PhaseW-1:0] PH_READ_H   = 5'd19;

    // Timing registers as seen by the sequencer
    typedef struct packed {
        logic [ShortW-1:0]   reset_low_us;
        logic [ShortW-1:0]   presence_timeout_us;
        logic [ShortW-1:0]   release_timeout_us;
        logic [CfgDataW-1:0] poll_wait_us;
    } owtr_cfg_t;

    // One result of the sequencer
    typedef struct packed {
        logic                    drive_low;
        logic                    busy_res;
        logic                    done_res;
        logic [ErrW-1:0]         error_code;
        logic signed [TempW-1:0] temperature;
    } owtr_res_t;

endpackage

>>> src/owtr_sample_if.sv
// Request channel carrying one microsecond tick: start request and line sample.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps

interface owtr_sample_if;
    logic valid;
    logic ready;
    logic start_req;
    logic line_level;

    modport source (output valid, output start_req, output line_level, input ready);
    modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

>>> src/owtr_result_if.sv
// Result channel: line drive, status and the last raw temperature.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps

interface owtr_result_if;
    logic              valid;
    logic              ready;
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic [1:0]        error_code;
    logic signed [15:0] temperature;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output error_code, output temperature, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input error_code, input temperature, output ready);
endinterface

>>> src/owtr_cfg.sv
// Timing register file of the temperature reader, written through a plain port.
// Depends on owtr_pkg.
`timescale 1ns / 1ps

module owtr_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [owtr_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [owtr_pkg::CfgDataW-1:0]   cfg_data,
    output owtr_pkg::owtr_cfg_t             cfg
);
    import owtr_pkg::*;

    owtr_cfg_t cfg_reg;

    // Register writes, each truncated to the width of its register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us        <= RESET_LOW_DEF;
            cfg_reg.presence_timeout_us <= PRES_TIMEOUT_DEF;
            cfg_reg.release_timeout_us  <= REL_TIMEOUT_DEF;
            cfg_reg.poll_wait_us        <= POLL_WAIT_DEF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESET_LOW:    cfg_reg.reset_low_us        <= cfg_data[ShortW-1:0];
                CFG_PRES_TIMEOUT: cfg_reg.presence_timeout_us <= cfg_data[ShortW-1:0];
                CFG_REL_TIMEOUT:  cfg_reg.release_timeout_us  <= cfg_data[ShortW-1:0];
                CFG_POLL_WAIT:    cfg_reg.poll_wait_us        <= cfg_data;
                default:          cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/owtr_seq.sv
// Bus sequencer: phase, tick counter, bit counter and shift byte, one step per tick.
// Depends on owtr_pkg.
`timescale 1ns / 1ps

module owtr_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  start_req,
    input  logic                  line_level,
    input  owtr_pkg::owtr_cfg_t   cfg,
    output owtr_pkg::owtr_res_t   res
);
    import owtr_pkg::*;

    logic [PhaseW-1:0]   phase_reg,   phase_next;
    logic [ElapsedW-1:0] elapsed_reg, elapsed_next;
    logic [BitIdxW-1:0]  bit_reg,     bit_next;
    logic [ByteW-1:0]    shift_reg,   shift_next;
    logic [ByteW-1:0]    low_reg,     low_next;
    logic [TempW-1:0]    held_reg,    held_next;

    logic [ElapsedW:0]   elapsed_inc;
    logic [ByteW-1:0]    cmd_byte;
    logic                cmd_bit;
    logic                is_write;
    logic                is_read;
    logic [ElapsedW-1:0] write_low;
    logic [ElapsedW-1:0] write_slot;
    logic [ByteW-1:0]    shift_smp;
    logic                drive;
    logic                busy;
    logic                ended;
    logic [ErrW-1:0]     end_code;
    logic                go;
    logic [PhaseW-1:0]   go_phase;

    // Decode of the current phase
    always_comb
    begin
        elapsed_inc = {1'b0, elapsed_reg} + 1'b1;
        case (phase_reg)
            PH_W_44: cmd_byte = CMD_CONVERT;
            PH_W_BE: cmd_byte = CMD_READ_PAD;
            default: cmd_byte = CMD_SKIP_ROM;
        endcase
        cmd_bit    = cmd_byte[bit_reg];
        is_write   = (phase_reg == PH_W_CC1) || (phase_reg == PH_W_44) ||
                     (phase_reg == PH_W_CC2) || (phase_reg == PH_W_BE);
        is_read    = (phase_reg == PH_POLL) || (phase_reg == PH_READ_L) ||
                     (phase_reg == PH_READ_H);
        write_low  = cmd_bit ? BIT1_LOW_US : BIT0_LOW_US;
        write_slot = cmd_bit ? BIT1_SLOT_US : BIT0_SLOT_US;
        shift_smp  = shift_reg;
        if ((elapsed_reg == RD_SAMPLE_US) && line_level)
        begin
            shift_smp[bit_reg] = 1'b1;
        end
    end

    // Line drive and busy follow the state at the start of the tick
    always_comb
    begin
        if ((phase_reg == PH_R1_LOW) || (phase_reg == PH_R2_LOW))
            drive = 1'b1;
        else if (is_write)
            drive = elapsed_reg < write_low;
        else if (is_read)
            drive = elapsed_reg < RD_LOW_US;
        else
            drive = 1'b0;
        busy = (phase_reg != PH_IDLE) && (phase_reg <= PH_READ_H);
    end

    // Next state; entering a phase clears the tick, bit and shift counters
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        low_next     = low_reg;
        held_next    = held_reg;
        ended        = 1'b0;
        end_code     = ERR_NONE;
        go           = 1'b0;
        go_phase     = PH_IDLE;

        case (phase_reg)
            PH_R1_LOW, PH_R2_LOW:
            begin
                if (elapsed_inc >= ({{(ElapsedW-ShortW){1'b0}}, 1'b0, cfg.reset_low_us}
                                    + {1'b0, EDGE_US}))
                begin
                    go       = 1'b1;
                    go_phase = phase_reg + 1'b1;
                end
                else
                    elapsed_next = elapsed_inc[ElapsedW-1:0];
            end
            PH_R1_REL, PH_R2_REL:
            begin
                if (elapsed_inc >= {1'b0, EDGE_US})
                begin
                    go       = 1'b1;
                    go_phase = phase_reg + 1'b1;
                end
                else
                    elapsed_next = elapsed_inc[ElapsedW-1:0];
            end
            PH_R1_PRES, PH_R2_PRES:
            begin
                if (!line_level)
                begin
                    go       = 1'b1;
                    go_phase = phase_reg + 1'b1;
                end
                else if (elapsed_reg > {{(ElapsedW-ShortW){1'b0}}, cfg.presence_timeout_us})
                begin
                    go       = 1'b1;
                    ended    = 1'b1;
                    end_code = ERR_NO_PRESENCE;
                end
                else
                    elapsed_next = elapsed_inc[ElapsedW-1:0];
            end
            PH_R1_FREE, PH_R2_FREE:
            begin
                if (line_level)
                begin
                    go       = 1'b1;
                    go_phase = (phase_reg == PH_R1_FREE) ? PH_WAIT10 : PH_W_CC2;
                end
                else if (elapsed_reg > {{(ElapsedW-ShortW){1'b0}}, cfg.release_timeout_us})
                begin
                    go       = 1'b1;
                    ended    = 1'b1;
                    end_code = ERR_NO_RELEASE;
                end
                else
                    elapsed_next = elapsed_inc[ElapsedW-1:0];
            end
            PH_WAIT10, PH_WAIT1A, PH_WAIT1B:
            begin
                if (elapsed_inc >= {1'b0, (phase_reg == PH_WAIT10) ? AFTER_RESET_US
                                                                    : AFTER_CMD_US})
                begin
                    go = 1'b1;
                    case (phase_reg)
                        PH_WAIT10: go_phase = PH_W_CC1;
                        PH_WAIT1A: go_phase = PH_POLL;
                        default:   go_phase = PH_READ_L;
                    endcase
                end
                else
                    elapsed_next = elapsed_inc[ElapsedW-1:0];
            end
            PH_POLLWAIT:
            begin
                if (elapsed_inc >= {1'b0, cfg.poll_wait_us})
                begin
                    go       = 1'b1;
                    go_phase = PH_POLL;
                end
                else
                    elapsed_next = elapsed_inc[ElapsedW-1:0];
            end
            PH_W_CC1, PH_W_44, PH_W_CC2, PH_W_BE:
            begin
                if (elapsed_inc < {1'b0, write_slot})
                    elapsed_next = elapsed_inc[ElapsedW-1:0];
                else if (bit_reg != {BitIdxW{1'b1}})
                begin
                    bit_next     = bit_reg + 1'b1;
                    elapsed_next = '0;
                end
                else
                begin
                    go = 1'b1;
                    case (phase_reg)
                        PH_W_CC1: go_phase = PH_W_44;
                        PH_W_44:  go_phase = PH_WAIT1A;
                        PH_W_CC2: go_phase = PH_W_BE;
                        default:  go_phase = PH_WAIT1B;
                    endcase
                end
            end
            PH_POLL, PH_READ_L, PH_READ_H:
            begin
                shift_next = shift_smp;
                if (elapsed_inc < {1'b0, RD_SLOT_US})
                    elapsed_next = elapsed_inc[ElapsedW-1:0];
                else if (bit_reg != {BitIdxW{1'b1}})
                begin
                    bit_next     = bit_reg + 1'b1;
                    elapsed_next = '0;
                end
                else
                begin
                    go = 1'b1;
                    case (phase_reg)
                        PH_POLL:
                            go_phase = (shift_smp == CONV_DONE) ? PH_R2_LOW : PH_POLLWAIT;
                        PH_READ_L:
                        begin
                            low_next = shift_smp;
                            go_phase = PH_READ_H;
                        end
                        default:
                        begin
                            held_next = {shift_smp, low_reg};
                            ended     = 1'b1;
                            end_code  = ERR_NONE;
                        end
                    endcase
                end
            end
            default:
            begin
                // Idle and unused codes: wait for a start request
                go       = 1'b1;
                go_phase = start_req ? PH_R1_LOW : PH_IDLE;
            end
        endcase

        if (go)
        begin
            phase_next   = go_phase;
            elapsed_next = '0;
            bit_next     = '0;
            shift_next   = '0;
        end
    end

    // State registers advance once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            low_reg     <= '0;
            held_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            low_reg     <= low_next;
            held_reg    <= held_next;
        end
    end

    assign res.drive_low   = drive;
    assign res.busy_res    = busy;
    assign res.done_res    = ended;
    assign res.error_code  = end_code;
    assign res.temperature = held_next;

`ifndef SYNTHESIS
    // The bit counter only moves inside byte slots.
    a_bit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (bit_reg == '0))
        else $error("bit counter nonzero while idle");

    // A sequence end always returns the sequencer to idle.
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && ended) |=> (phase_reg == PH_IDLE))
        else $error("sequence ended without returning to idle");

    // The temperature only changes at the end of the second read byte.
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        (held_next != held_reg) |-> (phase_reg == PH_READ_H))
        else $error("temperature changed outside the final read byte");
`endif

endmodule

>>> src/onewire_temperature_reader_core.sv
//  Channel  Dir   Payload                                            Handshake
//  sample   in    start_req, line_level                              valid/ready
//  result   out   drive_low, busy_res, done_res, error_code, temp.   valid/ready
//  cfg      in    cfg_index, cfg_data                                cfg_we
//
// One request is one microsecond tick and yields one result; a request is taken
// every cycle, one step of the sequencer between the tick and the result register.
// Reset puts the sequencer in idle, the timing registers at their defaults and
// the result register empty. A stalled result holds the next request back only
// while the result register is full and not taken.
// Depends on owtr_pkg, owtr_sample_if, owtr_result_if, owtr_cfg and owtr_seq.
`timescale 1ns / 1ps

module onewire_temperature_reader_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [owtr_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [owtr_pkg::CfgDataW-1:0]   cfg_data,
    owtr_sample_if.sink                     sample,
    owtr_result_if.source                   result
);
    import owtr_pkg::*;

    owtr_cfg_t cfg;
    owtr_res_t seq_res;
    owtr_res_t res_reg;
    logic      res_valid_reg;
    logic      step;

    owtr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A request is taken whenever the result register is free or being emptied
    assign sample.ready = !res_valid_reg || result.ready;
    assign step         = sample.valid && sample.ready;

    owtr_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .start_req  (sample.start_req),
        .line_level (sample.line_level),
        .cfg        (cfg),
        .res        (seq_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (step)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= seq_res;
    end

    assign result.valid       = res_valid_reg;
    assign result.drive_low   = res_reg.drive_low;
    assign result.busy_res    = res_reg.busy_res;
    assign result.done_res    = res_reg.done_res;
    assign result.error_code  = res_reg.error_code;
    assign result.temperature = res_reg.temperature;

`ifndef SYNTHESIS
    // Every accepted request leaves a result in the register.
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> res_valid_reg)
        else $error("accepted request left no result");

    // A sequence can only end while it was busy.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.done_res) |-> res_reg.busy_res)
        else $error("done without busy");

    // An error code appears only with done, and the line is released then.
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.error_code != ERR_NONE)) |->
            (res_reg.done_res && !res_reg.drive_low))
        else $error("error code without done or with line driven");
`endif

endmodule
